// ===== hdl/uniform_series_slot_binner_macros.svh =====
// Assertion macros shared by the binner RTL
`ifndef UNIFORM_SERIES_SLOT_BINNER_MACROS_SVH
`define UNIFORM_SERIES_SLOT_BINNER_MACROS_SVH

// implication checked every clock outside reset
`define USSB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked every clock outside reset
`define USSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ussb_pkg.sv =====
// ----------------------------------------------------------------------------
// ussb_pkg
// Types and constants of the uniform series slot binner.
// ----------------------------------------------------------------------------
package ussb_pkg;

    localparam int SERIES_DEPTH = 4096;
    localparam int AW = (SERIES_DEPTH > 1) ? $clog2(SERIES_DEPTH) : 1;
    localparam int CW = $clog2(SERIES_DEPTH + 1);

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_TRIM   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_QUIET = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_COUNT    = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_REC_WR,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_CLEAR,
        S_READ_RD,
        S_READ_CHK,
        S_OUT
    } state_t;

endpackage

// ===== hdl/ussb_ram.sv =====
// ----------------------------------------------------------------------------
// ussb_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module ussb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/uniform_series_slot_binner.sv =====
// ----------------------------------------------------------------------------
// uniform_series_slot_binner
// Bins timestamped samples into a uniform slot grid held in on-chip RAM.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass marks every slot
// missing before the first beat is taken; clear repeats that pass. A
// record runs a radix-2 restoring divider, one quotient bit a cycle over
// 48 bits. Trim visits each slot on the single RAM port with a read,
// then a check/write; the front and back walks may each visit every
// slot in use. The result sits in an output register until taken.
// Values and missing flags share one 33-bit RAM word.
module uniform_series_slot_binner (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata: sample_time[47:0], sample_value[79:48], read_slot[91:80], zero pad
    input  logic [95:0]         s_tdata,
    // tuser: operation[1:0], trim_front[2], trim_back[3]
    input  logic [3:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: status[1:0], bad_seen[2], trimmed_count[15:3], slot_value[47:16],
    //        slot_missing[48], zero pad
    output logic [55:0]         m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [47:0]         cfg_data
);
    import ussb_pkg::*;

    state_t state_reg, state_next;

    logic [47:0] start_reg;
    logic [31:0] interval_reg;
    logic [12:0] count_reg;
    logic        bad_reg, bad_next;

    logic [1:0]  op_reg;
    logic [47:0] time_reg;
    logic [31:0] value_reg;
    logic        front_reg, back_reg;
    logic [11:0] rslot_reg;

    // divider
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0]  bit_reg, bit_next;

    // trim walk
    logic [CW-1:0] idx_reg, idx_next;
    logic          phase_reg, phase_next;   // 0 front, 1 back
    logic [CW-1:0] tcnt_reg, tcnt_next;
    logic [CW-1:0] ecount;

    logic [1:0]  ostat_reg, ostat_next;
    logic [31:0] oval_reg, oval_next;
    logic        omiss_reg, omiss_next;
    logic        ovalid_reg, ovalid_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [32:0]   ram_wdata, ram_rdata;

    ussb_ram #(.WIDTH(33), .DEPTH(SERIES_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ecount = (32'(count_reg) > 32'(SERIES_DEPTH))
                    ? CW'(SERIES_DEPTH) : CW'(count_reg);

    assign s_tready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {7'd0, omiss_reg, oval_reg,
                        (op_reg == OP_TRIM) ? tcnt_reg : '0, bad_reg, ostat_reg};

    logic [47:0] delta;
    logic [32:0] rem_sh;
    logic        rec_quiet;
    logic        walk_end;
    logic [CW-1:0] slot_idx;

    assign delta     = time_reg - start_reg;
    assign rem_sh    = {rem_reg[31:0], delta[bit_reg]};
    assign rec_quiet = (interval_reg == 32'd0) || (time_reg < start_reg);
    // front walks idx up from 0; back walks idx down from ecount (slot idx-1)
    assign slot_idx  = phase_reg ? idx_reg - CW'(1) : idx_reg;
    assign walk_end  = phase_reg ? (idx_reg == '0) : (idx_reg >= ecount);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT, S_CLEAR:
                if (idx_reg == CW'(SERIES_DEPTH - 1))
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_OUT;
            S_IDLE:
                if (s_tvalid && s_tready)
                begin
                    case (s_tuser[1:0])
                        OP_RECORD: state_next = S_DIV;
                        OP_TRIM:   state_next = S_TRIM_RD;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_READ_RD;
                    endcase
                end
            S_DIV:
                if (rec_quiet) state_next = S_OUT;
                else if (bit_reg == 6'd0) state_next = S_REC_WR;
            S_REC_WR:  state_next = S_OUT;
            S_TRIM_RD:
                if (walk_end || (phase_reg ? !back_reg : !front_reg))
                    state_next = (phase_reg || !back_reg) ? S_OUT : S_TRIM_RD;
                else state_next = S_TRIM_CHK;
            S_TRIM_CHK:
                if (!ram_rdata[32] && ram_rdata[31:0] != 32'd0)
                    state_next = (phase_reg || !back_reg) ? S_OUT : S_TRIM_RD;
                else state_next = S_TRIM_RD;
            S_READ_RD:  state_next = S_READ_CHK;
            S_READ_CHK: state_next = S_OUT;
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        tcnt_next   = tcnt_reg;
        bad_next    = bad_reg;
        ostat_next  = ostat_reg;
        oval_next   = oval_reg;
        omiss_next  = omiss_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ram_we      = 1'b0;
        ram_addr    = idx_reg[AW-1:0];
        ram_wdata   = {1'b1, 32'd0};
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (state_reg == S_CLEAR) bad_next = 1'b0;
            end
            S_IDLE:
            begin
                // result fields hold while a result beat waits
                if (s_tvalid && s_tready)
                begin
                    idx_next   = '0;
                    phase_next = 1'b0;
                    tcnt_next  = '0;
                    bit_next   = 6'd47;
                    rem_next   = '0;
                    ostat_next = ST_OK;
                    oval_next  = '0;
                    omiss_next = 1'b0;
                end
            end
            S_DIV:
            begin
                if (rec_quiet) ostat_next = ST_QUIET;
                else
                begin
                    if (rem_sh >= {1'b0, interval_reg})
                    begin
                        rem_next = rem_sh - {1'b0, interval_reg};
                        quo_next = {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[46:0], 1'b0};
                    end
                    bit_next = bit_reg - 6'd1;
                end
            end
            S_REC_WR:
            begin
                if (rem_reg != '0 || quo_reg >= 48'(ecount))
                begin
                    ostat_next = ST_BAD;
                    bad_next   = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_addr  = quo_reg[AW-1:0];
                    ram_wdata = {1'b0, value_reg};
                end
            end
            S_TRIM_RD:
            begin
                ram_addr = slot_idx[AW-1:0];
                if (walk_end || (phase_reg ? !back_reg : !front_reg))
                begin
                    phase_next = 1'b1;
                    idx_next   = ecount;
                end
            end
            S_TRIM_CHK:
            begin
                ram_addr = slot_idx[AW-1:0];
                if (!ram_rdata[32] && ram_rdata[31:0] != 32'd0)
                begin
                    phase_next = 1'b1;
                    idx_next   = ecount;
                end
                else
                begin
                    if (!ram_rdata[32])
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, ram_rdata[31:0]};
                        tcnt_next = tcnt_reg + CW'(1);
                    end
                    idx_next = phase_reg ? idx_reg - CW'(1) : idx_reg + CW'(1);
                end
            end
            S_READ_RD:
                ram_addr = rslot_reg[AW-1:0];
            S_READ_CHK:
            begin
                if (32'(rslot_reg) < 32'(SERIES_DEPTH) && !ram_rdata[32])
                    oval_next = ram_rdata[31:0];
                else omiss_next = 1'b1;
            end
            S_OUT:
                ovalid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            start_reg    <= '0;
            interval_reg <= '0;
            count_reg    <= '0;
            bad_reg      <= 1'b0;
            idx_reg      <= '0;
            phase_reg    <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bad_reg    <= bad_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START:    start_reg    <= cfg_data;
                    REG_INTERVAL: interval_reg <= cfg_data[31:0];
                    REG_COUNT:    count_reg    <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        tcnt_reg  <= tcnt_next;
        ostat_reg <= ostat_next;
        oval_reg  <= oval_next;
        omiss_reg <= omiss_next;
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser[1:0];
            front_reg <= s_tuser[2];
            back_reg  <= s_tuser[3];
            time_reg  <= s_tdata[47:0];
            value_reg <= s_tdata[79:48];
            rslot_reg <= s_tdata[91:80];
        end
    end

`include "uniform_series_slot_binner_macros.svh"

    `USSB_ASSERT_IMP(a_no_accept_busy, state_reg != S_IDLE, !s_tready)
    `USSB_ASSERT_IMP(a_out_only_idle, m_tvalid, state_reg == S_IDLE)
    `USSB_ASSERT_NEXT(a_out_follows, state_reg == S_OUT, m_tvalid)
    `USSB_ASSERT_IMP(a_bad_status, m_tvalid && ostat_reg == ST_BAD, bad_reg)

endmodule

// ===== bench/ussb_checker.sv =====
// ----------------------------------------------------------------------------
// ussb_checker
// Watches the input, config and result channels of the slot binner. Keeps
// its own copy of the slot store and registers, predicts one result per
// accepted input beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module ussb_checker
    import ussb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic        bad_seen;
        logic [12:0] trimmed_count;
        logic [31:0] slot_value;
        logic        slot_missing;
    } bin_result_t;

    logic [47:0] start_time;
    logic [31:0] interval;
    logic [12:0] count_reg;
    logic [31:0] slot_vals [SERIES_DEPTH];
    logic        slot_gone [SERIES_DEPTH];
    logic        bad_flag;

    bin_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic int used_slots();
        return (count_reg > SERIES_DEPTH) ? SERIES_DEPTH : int'(count_reg);
    endfunction

    // true while the trim walk may continue past slot i
    function automatic bit trim_slot(int i, ref int n);
        if (slot_gone[i])
            return 1;
        if (slot_vals[i] != 0)
            return 0;
        slot_gone[i] = 1;
        n++;
        return 1;
    endfunction

    function automatic bin_result_t predict_bin(logic [1:0] op, logic [47:0] t,
                                                logic [31:0] v, logic front,
                                                logic back, logic [11:0] rs);
        bin_result_t r;
        logic [47:0] delta;
        logic [47:0] slot;
        int n;
        int cnt;
        r = '0;
        n = used_slots();
        cnt = 0;
        case (op)
            OP_RECORD:
            begin
                if (interval == 0 || t < start_time)
                    r.status = ST_QUIET;
                else
                begin
                    delta = t - start_time;
                    slot = delta / interval;
                    if (delta % interval != 0 || slot >= n)
                    begin
                        bad_flag = 1;
                        r.status = ST_BAD;
                    end
                    else
                    begin
                        slot_vals[slot] = v;
                        slot_gone[slot] = 0;
                        r.status = ST_OK;
                    end
                end
            end
            OP_TRIM:
            begin
                if (front)
                    for (int i = 0; i < n; i++)
                        if (!trim_slot(i, cnt))
                            break;
                if (back)
                    for (int i = n - 1; i >= 0; i--)
                        if (!trim_slot(i, cnt))
                            break;
                r.trimmed_count = cnt[12:0];
            end
            OP_CLEAR:
            begin
                foreach (slot_gone[i])
                    slot_gone[i] = 1;
                bad_flag = 0;
            end
            default:
            begin
                if (slot_gone[rs])
                    r.slot_missing = 1;
                else
                    r.slot_value = slot_vals[rs];
            end
        endcase
        r.bad_seen = bad_flag;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        start_time = '0;
        interval = '0;
        count_reg = '0;
        bad_flag = 0;
        foreach (slot_gone[i])
        begin
            slot_gone[i] = 1;
            slot_vals[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        bin_result_t got;
        bin_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START:    start_time = cfg_data;
                    REG_INTERVAL: interval = cfg_data[31:0];
                    REG_COUNT:    count_reg = cfg_data[12:0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_bin(s_tuser[1:0], s_tdata[47:0],
                    s_tdata[79:48], s_tuser[2], s_tuser[3], s_tdata[91:80]));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[1:0], m_tdata[2], m_tdata[15:3], m_tdata[47:16],
                       m_tdata[48]};
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.bad_seen !== want.bad_seen)
                    begin
                        $error("bad_seen expected %0d got %0d", want.bad_seen,
                               got.bad_seen);
                        fail_count++;
                    end
                    if (got.trimmed_count !== want.trimmed_count)
                    begin
                        $error("trimmed_count expected %0d got %0d",
                               want.trimmed_count, got.trimmed_count);
                        fail_count++;
                    end
                    if (got.slot_value !== want.slot_value)
                    begin
                        $error("slot_value expected %h got %h", want.slot_value,
                               got.slot_value);
                        fail_count++;
                    end
                    if (got.slot_missing !== want.slot_missing)
                    begin
                        $error("slot_missing expected %0d got %0d",
                               want.slot_missing, got.slot_missing);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the slot binner: directed corner items, then random phases
// under several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import ussb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    int          fail_count;
    int          pending;
    int          stall_cycles;
    bit          no_idle;

    uniform_series_slot_binner i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ussb_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 29);

    // nothing accepted for too long: hang
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic send_item(logic [1:0] op, logic [47:0] t, logic [31:0] v,
                             logic front, logic back, logic [11:0] rs);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tdata <= {4'b0, rs, v, t};
        s_tuser <= {back, front, op};
        s_tvalid <= 1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] data);
        @(negedge clk);
        s_tvalid <= 0;
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(logic [47:0] st, logic [31:0] ivl, logic [12:0] cnt,
                             int items);
        logic [63:0] t;
        logic [31:0] v;
        logic [11:0] rs;
        logic [1:0]  op;
        int          pick;
        int          n;
        drain();
        write_reg(REG_START, st);
        write_reg(REG_INTERVAL, {16'b0, ivl});
        write_reg(REG_COUNT, {35'b0, cnt});
        n = (cnt > SERIES_DEPTH) ? SERIES_DEPTH : int'(cnt);
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 99);
            op = (pick < 55) ? OP_RECORD : (pick < 67) ? OP_TRIM :
                 (pick < 71) ? OP_CLEAR : OP_READ;
            // big series make trims slow, keep them rare there
            if (op == OP_TRIM && n > 256 && $urandom_range(0, 3) != 0)
                op = OP_READ;
            v = ($urandom_range(0, 99) < 40) ? 32'd0 : $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                t = st + 64'($urandom_range(0, n + 2)) * ivl;
            else if (pick < 80)
                t = st + 64'($urandom_range(0, n)) * ivl
                    + ((ivl > 1) ? $urandom_range(1, ivl - 1) : 1);
            else if (pick < 88 && st > 0)
                t = 64'(rand48() % st);
            else
                t = 64'(rand48());
            rs = ($urandom_range(0, 99) < 80) ? 12'($urandom_range(0, n + 2))
                                              : 12'($urandom());
            send_item(op, t[47:0], v, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), rs);
        end
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 0;
        cfg_index = REG_START;
        cfg_data = '0;
        m_tready = 0;
        no_idle = 0;
        stall_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset registers: zero interval, zero count
        send_item(OP_RECORD, 48'd0, 32'd5, 0, 0, 12'd0);
        send_item(OP_TRIM, 48'd0, 32'd0, 1, 1, 12'd0);
        send_item(OP_READ, 48'd0, 32'd0, 0, 0, 12'd4095);
        send_item(OP_READ, 48'd0, 32'd0, 0, 0, 12'd0);
        drain();
        write_reg(REG_START, 48'd100);
        write_reg(REG_INTERVAL, 48'd10);
        write_reg(REG_COUNT, 48'd8);
        send_item(OP_RECORD, 48'd90, 32'd1, 0, 0, 12'd0);          // before start
        send_item(OP_RECORD, 48'd105, 32'd1, 0, 0, 12'd0);         // off grid
        send_item(OP_RECORD, 48'd180, 32'd1, 0, 0, 12'd0);         // slot == count
        send_item(OP_RECORD, 48'd100, 32'd0, 0, 0, 12'd0);
        send_item(OP_RECORD, 48'd110, 32'h8000_0000, 0, 0, 12'd0);
        send_item(OP_RECORD, 48'd160, 32'h7fff_ffff, 0, 0, 12'd0);
        send_item(OP_RECORD, 48'd170, 32'd0, 0, 0, 12'd0);
        send_item(OP_RECORD, 48'd150, 32'hffff_ffff, 0, 0, 12'd0);
        send_item(OP_READ, 48'd0, 32'd0, 0, 0, 12'd1);
        send_item(OP_READ, 48'd0, 32'd0, 0, 0, 12'd2);             // missing
        send_item(OP_TRIM, 48'd0, 32'd0, 1, 1, 12'd0);
        send_item(OP_READ, 48'd0, 32'd0, 0, 0, 12'd0);
        send_item(OP_TRIM, 48'd0, 32'd0, 1, 0, 12'd0);
        send_item(OP_CLEAR, 48'd0, 32'd0, 0, 0, 12'd0);
        send_item(OP_READ, 48'd0, 32'd0, 0, 0, 12'd1);
        send_item(OP_RECORD, 48'hffff_ffff_ffff, 32'd3, 0, 0, 12'd0);

        run_phase(48'd1000, 32'd7, 13'd16, 200);
        no_idle = 1;
        run_phase(48'd0, 32'd1, 13'd40, 200);
        no_idle = 0;
        run_phase(48'hffff_ffff_ffff - 48'd5 * 48'hffff_ffff, 32'hffff_ffff, 13'd8191,
                  120);
        run_phase(rand48(), 32'($urandom_range(1, 65535)), 13'd64, 230);
        run_phase(48'd0, 32'd0, 13'd30, 80);
        run_phase(48'd5, 32'd3, 13'd0, 80);
        run_phase(48'd200, 32'd2, 13'd4096, 100);
        run_phase(rand48() >> 8, $urandom(), 13'($urandom_range(1, 48)), 140);

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
